FILE: hw/rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, register indexes and helpers of the glyph row rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed register field widths
    localparam int CANVAS_W = 10;
    localparam int GW_W     = 4;
    localparam int SCALE_W  = 4;
    localparam int COLOR_W  = 16;
    localparam int ROW_W    = 3;
    localparam int ADDR_W   = 20;
    localparam int LEN_W    = 4;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIMARY_COLOR = 3'd4;

    // Reset values of the registers
    localparam logic [CANVAS_W-1:0] RST_CANVAS_WIDTH  = 10'd160;
    localparam logic [CANVAS_W-1:0] RST_CANVAS_HEIGHT = 10'd144;
    localparam logic [GW_W-1:0]     RST_GLYPH_WIDTH   = 4'd8;
    localparam logic [SCALE_W-1:0]  RST_SCALE         = 4'd1;
    localparam logic [COLOR_W-1:0]  RST_PRIMARY_COLOR = 16'hFFFF;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [CANVAS_W-1:0] canvas_width;
        logic [CANVAS_W-1:0] canvas_height;
        logic [GW_W-1:0]     glyph_width;
        logic [SCALE_W-1:0]  scale;
        logic [COLOR_W-1:0]  primary_color;
    } cfg_t;

    // Clamp a 4-bit setting to an upper limit
    function automatic logic [3:0] sat4(input logic [3:0] value, input logic [3:0] limit);
        sat4 = (value > limit) ? limit : value;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sgr_fifo.sv
// ----------------------------------------------------------------------------
// sgr_fifo
// Short queue of classified rows between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue occupancy above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop without push did not shrink the queue");

endmodule

`default_nettype wire

FILE: hw/rtl/sgr_front.sv
// ----------------------------------------------------------------------------
// sgr_front
// Accepts glyph rows, works out the drawable columns and sub-row count,
// and queues rows that yield at least one span.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_front #(
    parameter int GLYPH_BITS = 8,
    parameter int MAX_SCALE  = 8,
    parameter int COORD_BITS = 10,
    parameter int ENTRY_W    = GLYPH_BITS + 2 * COORD_BITS + 1 + 4
) (
    input  wire sgr_pkg::cfg_t                  cfg,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [GLYPH_BITS-1:0]          row_bits,
    input  wire logic [sgr_pkg::ROW_W-1:0]      row_index,
    input  wire logic [COORD_BITS-1:0]          origin_x,
    input  wire logic [COORD_BITS-1:0]          origin_y,
    output logic                                push,
    output logic [ENTRY_W-1:0]                  push_data,
    input  wire logic                           queue_full
);

    localparam int XW    = COORD_BITS + 1;
    localparam int CMP_W = (XW > sgr_pkg::CANVAS_W) ? XW : sgr_pkg::CANVAS_W;

    logic [3:0]            sc_sat;
    logic [3:0]            gw_sat;
    logic [GLYPH_BITS-1:0] col_mask;
    logic [XW-1:0]         col_x;
    logic [XW-1:0]         y0;
    logic [CMP_W-1:0]      rows_left;
    logic [3:0]            nsub;
    logic                  keep;

    assign sc_sat = sgr_pkg::sat4(cfg.scale, 4'(MAX_SCALE));
    assign gw_sat = sgr_pkg::sat4(cfg.glyph_width, 4'(GLYPH_BITS));

    // Mark set bits whose square starts inside the canvas
    always_comb
    begin
        col_mask = '0;
        col_x    = '0;
        for (int i = 0; i < GLYPH_BITS; i++)
        begin
            col_x = XW'(origin_x) + XW'(i) * XW'(sc_sat);
            col_mask[i] = row_bits[GLYPH_BITS-1-i] && (4'(i) < gw_sat)
                          && (CMP_W'(col_x) < CMP_W'(cfg.canvas_width));
        end
    end

    // Count sub-rows above the bottom edge
    always_comb
    begin
        y0        = XW'(origin_y) + XW'(row_index) * XW'(sc_sat);
        rows_left = '0;
        nsub      = 4'd0;
        if (CMP_W'(y0) < CMP_W'(cfg.canvas_height))
        begin
            rows_left = CMP_W'(cfg.canvas_height) - CMP_W'(y0);
            nsub = (rows_left > CMP_W'(sc_sat)) ? sc_sat : rows_left[3:0];
        end
    end

    // Queue rows that produce spans, drop the rest at accept
    assign keep      = (col_mask != '0) && (nsub != 4'd0);
    assign in_stall  = queue_full;
    assign push      = in_valid && !queue_full && keep;
    assign push_data = {col_mask, origin_x, y0, nsub};

endmodule

`default_nettype wire

FILE: hw/rtl/sgr_back.sv
// ----------------------------------------------------------------------------
// sgr_back
// Walks the queued columns and sub-rows of one row and emits one span word
// per cycle into the output register while out_stall does not hold it.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_back #(
    parameter int GLYPH_BITS = 8,
    parameter int MAX_SCALE  = 8,
    parameter int COORD_BITS = 10,
    parameter int ENTRY_W    = GLYPH_BITS + 2 * COORD_BITS + 1 + 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire sgr_pkg::cfg_t                  cfg,
    input  wire logic                           queue_empty,
    input  wire logic [ENTRY_W-1:0]             pop_data,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [sgr_pkg::ADDR_W-1:0]          span_address,
    output logic [sgr_pkg::LEN_W-1:0]           span_length,
    output logic [sgr_pkg::COLOR_W-1:0]         span_color,
    output logic                                last_span
);

    localparam int XW    = COORD_BITS + 1;
    localparam int CMP_W = (XW > sgr_pkg::CANVAS_W) ? XW : sgr_pkg::CANVAS_W;
    localparam int COL_W = (GLYPH_BITS > 1) ? $clog2(GLYPH_BITS) : 1;
    localparam int PW    = XW + sgr_pkg::CANVAS_W + 1;
    localparam int SUM_W = (PW > sgr_pkg::ADDR_W) ? PW : sgr_pkg::ADDR_W;

    // Row under work
    logic                  busy_reg, busy_next;
    logic [GLYPH_BITS-1:0] mask_reg, mask_next;
    logic [COORD_BITS-1:0] ox_reg, ox_next;
    logic [XW-1:0]         y0_reg, y0_next;
    logic [3:0]            nsub_reg, nsub_next;
    logic [3:0]            sub_reg, sub_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [sgr_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [sgr_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [sgr_pkg::COLOR_W-1:0]   color_reg, color_next;
    logic                          last_reg, last_next;

    logic [GLYPH_BITS-1:0] q_mask;
    logic [COORD_BITS-1:0] q_ox;
    logic [XW-1:0]         q_y0;
    logic [3:0]            q_nsub;

    logic [3:0]            sc_sat;
    logic [COL_W-1:0]      col;
    logic [XW-1:0]         x;
    logic [XW-1:0]         y;
    logic [SUM_W-1:0]      addr_sum;
    logic [CMP_W-1:0]      room;
    logic [3:0]            len;
    logic                  col_done;
    logic [GLYPH_BITS-1:0] mask_after;
    logic                  row_last;
    logic                  out_free;
    logic                  emit;

    assign {q_mask, q_ox, q_y0, q_nsub} = pop_data;
    assign sc_sat = sgr_pkg::sat4(cfg.scale, 4'(MAX_SCALE));

    // Pick the leftmost pending column
    always_comb
    begin
        col = '0;
        for (int i = GLYPH_BITS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                col = COL_W'(i);
            end
        end
    end

    // Span geometry for the current column and sub-row
    always_comb
    begin
        x        = XW'(ox_reg) + XW'(col) * XW'(sc_sat);
        y        = y0_reg + XW'(sub_reg);
        addr_sum = SUM_W'(y) * SUM_W'(cfg.canvas_width) + SUM_W'(x);
        room     = CMP_W'(cfg.canvas_width) - CMP_W'(x);
        len      = (room < CMP_W'(sc_sat)) ? room[3:0] : sc_sat;
    end

    assign col_done   = (sub_reg + 4'd1 == nsub_reg);
    assign mask_after = col_done ? (mask_reg & ~(GLYPH_BITS'(1) << col)) : mask_reg;
    assign row_last   = col_done && (mask_after == '0);
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit       = busy_reg && out_free;
    assign pop        = !busy_reg && !queue_empty;

    // Load a row, then step sub-rows and columns
    always_comb
    begin
        busy_next      = busy_reg;
        mask_next      = mask_reg;
        ox_next        = ox_reg;
        y0_next        = y0_reg;
        nsub_next      = nsub_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        color_next     = color_reg;
        last_next      = last_reg;

        if (pop)
        begin
            busy_next = 1'b1;
            mask_next = q_mask;
            ox_next   = q_ox;
            y0_next   = q_y0;
            nsub_next = q_nsub;
            sub_next  = 4'd0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            addr_next      = addr_sum[sgr_pkg::ADDR_W-1:0];
            len_next       = len;
            color_next     = cfg.primary_color;
            last_next      = row_last;
            mask_next      = mask_after;
            sub_next       = col_done ? 4'd0 : sub_reg + 4'd1;
            busy_next      = !row_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        ox_reg    <= ox_next;
        y0_reg    <= y0_next;
        nsub_reg  <= nsub_next;
        sub_reg   <= sub_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign span_address = addr_reg;
    assign span_length  = len_reg;
    assign span_color   = color_reg;
    assign last_span    = last_reg;

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (len_reg != 4'd0 && len_reg <= 4'(MAX_SCALE)))
        else $error("span length out of range");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && row_last) |=> (!busy_reg && last_reg))
        else $error("row did not end after its last span");

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (mask_reg != '0 && sub_reg < nsub_reg))
        else $error("back end busy without pending spans");

endmodule

`default_nettype wire

FILE: hw/rtl/scaled_glyph_row_rasterizer.sv
// ----------------------------------------------------------------------------
// scaled_glyph_row_rasterizer
// Expands one glyph bitmap row into clipped, scaled framebuffer span words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one word per row: row_bits,
//   row_index, origin_x, origin_y. Output channel (out_valid / out_stall)
//   gives one span word per cycle while out_stall is low: span_address,
//   span_length, span_color, last_span (set on the final span of each row).
//   Registers are written through cfg_we / cfg_index / cfg_data; the user
//   must write them only while the block is idle, which it does not enforce.
//   The first span of a row passes the queue, the back end row registers
//   and the output register. The front classifies a row in its accept
//   cycle, so rows with no visible span are dropped and produce nothing.
//   The back end emits one span per cycle while out_stall is low, takes
//   the next row from the queue only after the last span of the current
//   one, and emits nothing in the cycle in which it loads a row.
//   A two-entry queue lets the front keep accepting rows while the back end
//   works; in_stall rises only when that queue is full.
//   When out_stall is high while a span word is valid, the word holds and the back end pauses.
//   Reset restores the register defaults and empties queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_glyph_row_rasterizer #(
    parameter int GLYPH_BITS = 8,
    parameter int MAX_SCALE  = 8,
    parameter int COORD_BITS = 10
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sgr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [GLYPH_BITS-1:0]              row_bits,
    input  wire logic [sgr_pkg::ROW_W-1:0]          row_index,
    input  wire logic [COORD_BITS-1:0]              origin_x,
    input  wire logic [COORD_BITS-1:0]              origin_y,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [sgr_pkg::ADDR_W-1:0]              span_address,
    output logic [sgr_pkg::LEN_W-1:0]               span_length,
    output logic [sgr_pkg::COLOR_W-1:0]             span_color,
    output logic                                    last_span
);

    localparam int ENTRY_W = GLYPH_BITS + 2 * COORD_BITS + 1 + 4;

    sgr_pkg::cfg_t    cfg_reg;
    logic             push;
    logic [ENTRY_W-1:0] push_data;
    logic             queue_full;
    logic             pop;
    logic [ENTRY_W-1:0] pop_data;
    logic             queue_empty;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canvas_width  <= sgr_pkg::RST_CANVAS_WIDTH;
            cfg_reg.canvas_height <= sgr_pkg::RST_CANVAS_HEIGHT;
            cfg_reg.glyph_width   <= sgr_pkg::RST_GLYPH_WIDTH;
            cfg_reg.scale         <= sgr_pkg::RST_SCALE;
            cfg_reg.primary_color <= sgr_pkg::RST_PRIMARY_COLOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgr_pkg::CFG_CANVAS_WIDTH:
                    cfg_reg.canvas_width  <= cfg_data[sgr_pkg::CANVAS_W-1:0];
                sgr_pkg::CFG_CANVAS_HEIGHT:
                    cfg_reg.canvas_height <= cfg_data[sgr_pkg::CANVAS_W-1:0];
                sgr_pkg::CFG_GLYPH_WIDTH:
                    cfg_reg.glyph_width   <= cfg_data[sgr_pkg::GW_W-1:0];
                sgr_pkg::CFG_SCALE:
                    cfg_reg.scale         <= cfg_data[sgr_pkg::SCALE_W-1:0];
                sgr_pkg::CFG_PRIMARY_COLOR:
                    cfg_reg.primary_color <= cfg_data[sgr_pkg::COLOR_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    sgr_front #(
        .GLYPH_BITS (GLYPH_BITS),
        .MAX_SCALE  (MAX_SCALE),
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_bits   (row_bits),
        .row_index  (row_index),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    sgr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (sgr_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    sgr_back #(
        .GLYPH_BITS (GLYPH_BITS),
        .MAX_SCALE  (MAX_SCALE),
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_empty  (queue_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .span_address (span_address),
        .span_length  (span_length),
        .span_color   (span_color),
        .last_span    (last_span)
    );

endmodule

`default_nettype wire

FILE: bench/scaled_glyph_row_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// scaled_glyph_row_rasterizer_tb
// Self-checking bench for the scaled glyph row rasterizer. Rows are offered
// with random gaps, spans are taken with random stalls, and each span word is
// compared with the spans that a local model of the block works out per row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scaled_glyph_row_rasterizer_tb;

    localparam int          HALF_PERIOD    = 5;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          ROWS_PER_PHASE = 26;
    localparam logic [sgr_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd5;

    // One span word as seen on the output
    typedef struct packed {
        logic [sgr_pkg::ADDR_W-1:0]  address;
        logic [sgr_pkg::LEN_W-1:0]   length;
        logic [sgr_pkg::COLOR_W-1:0] color;
        logic                        is_last;
    } span_t;

    // ------------------------------------------------------------------------
    // Span scoreboard: mirrors the registers and holds the spans still owed
    // ------------------------------------------------------------------------
    class span_scoreboard;
        int unsigned canvas_w;
        int unsigned canvas_h;
        int unsigned glyph_w;
        int unsigned zoom;
        logic [sgr_pkg::COLOR_W-1:0] color;
        span_t owed_spans[$];
        int error_count;

        function new();
            canvas_w    = sgr_pkg::RST_CANVAS_WIDTH;
            canvas_h    = sgr_pkg::RST_CANVAS_HEIGHT;
            glyph_w     = sgr_pkg::RST_GLYPH_WIDTH;
            zoom        = sgr_pkg::RST_SCALE;
            color       = sgr_pkg::RST_PRIMARY_COLOR;
            error_count = 0;
        endfunction

        function void set_reg(logic [sgr_pkg::CFG_INDEX_W-1:0] idx,
                              logic [sgr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                sgr_pkg::CFG_CANVAS_WIDTH:  canvas_w = data[sgr_pkg::CANVAS_W-1:0];
                sgr_pkg::CFG_CANVAS_HEIGHT: canvas_h = data[sgr_pkg::CANVAS_W-1:0];
                sgr_pkg::CFG_GLYPH_WIDTH:   glyph_w  = data[sgr_pkg::GW_W-1:0];
                sgr_pkg::CFG_SCALE:         zoom     = data[sgr_pkg::SCALE_W-1:0];
                sgr_pkg::CFG_PRIMARY_COLOR: color    = data[sgr_pkg::COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_spans.size();
        endfunction

        // Expand one accepted row into the spans it owes, last one marked
        function void note_row(logic [7:0] bits, logic [2:0] row,
                               logic [9:0] ox, logic [9:0] oy);
            int unsigned g;
            int unsigned s;
            int unsigned x;
            int unsigned y;
            int unsigned y0;
            int unsigned len;
            int unsigned lin;
            span_t held;
            bit have_held;
            g = (glyph_w > 8) ? 8 : glyph_w;
            s = (zoom > 8) ? 8 : zoom;
            have_held = 1'b0;
            held = '0;
            if (s == 0 || bits == 8'h00)
                return;
            for (int col = 0; col < int'(g); col++)
            begin
                if (!bits[7-col])
                    continue;
                x = int'(ox) + col * s;
                if (x >= canvas_w)
                    continue;
                len = canvas_w - x;
                if (len > s)
                    len = s;
                y0 = int'(oy) + int'(row) * s;
                for (int sub = 0; sub < int'(s); sub++)
                begin
                    y = y0 + sub;
                    if (y >= canvas_h)
                        break;
                    // Push the previous span now that a later one exists
                    if (have_held)
                        owed_spans.push_back(held);
                    lin          = y * canvas_w + x;
                    held.address = lin[sgr_pkg::ADDR_W-1:0];
                    held.length  = len[sgr_pkg::LEN_W-1:0];
                    held.color   = color;
                    held.is_last = 1'b0;
                    have_held    = 1'b1;
                end
            end
            if (have_held)
            begin
                held.is_last = 1'b1;
                owed_spans.push_back(held);
            end
        endfunction

        task report_mismatch(string msg);
            error_count++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Compare a received span word with the oldest one owed
        task check_span(span_t got);
            span_t want;
            if (owed_spans.size() == 0)
            begin
                report_mismatch($sformatf("unexpected span addr=%0d len=%0d",
                                          got.address, got.length));
                return;
            end
            want = owed_spans.pop_front();
            if (got.address !== want.address)
                report_mismatch($sformatf("span_address got %0d want %0d",
                                          got.address, want.address));
            if (got.length !== want.length)
                report_mismatch($sformatf("span_length got %0d want %0d",
                                          got.length, want.length));
            if (got.color !== want.color)
                report_mismatch($sformatf("span_color got %h want %h",
                                          got.color, want.color));
            if (got.is_last !== want.is_last)
                report_mismatch($sformatf("last_span got %b want %b",
                                          got.is_last, want.is_last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [sgr_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [sgr_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [7:0]                          row_bits = '0;
    logic [sgr_pkg::ROW_W-1:0]           row_index = '0;
    logic [9:0]                          origin_x = '0;
    logic [9:0]                          origin_y = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [sgr_pkg::ADDR_W-1:0]          span_address;
    logic [sgr_pkg::LEN_W-1:0]           span_length;
    logic [sgr_pkg::COLOR_W-1:0]         span_color;
    logic                                last_span;

    span_scoreboard sb;
    bit             burst = 1'b0;
    bit             hold_req = 1'b0;
    int             hold_left = 0;
    int             stall_left = 0;
    int             quiet_cycles = 0;

    scaled_glyph_row_rasterizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row_bits     (row_bits),
        .row_index    (row_index),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .span_address (span_address),
        .span_length  (span_length),
        .span_color   (span_color),
        .last_span    (last_span)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // Gap before a word: none during a burst stretch
    function automatic int pick_gap();
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls per span word, plus the long hold-off
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left  = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req   = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Check each accepted span word and draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_span({span_address, span_length, span_color, last_span});
            stall_left = pick_gap();
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // Write one register, filling the unused upper data bits at random
    task automatic write_reg(logic [sgr_pkg::CFG_INDEX_W-1:0] idx, int unsigned value,
                             int nbits);
        logic [31:0]                   raw;
        logic [sgr_pkg::CFG_DATA_W-1:0] data;
        raw  = ({$urandom} << nbits) | value;
        data = raw[sgr_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int unsigned cw, int unsigned ch, int unsigned gw,
                           int unsigned sc, int unsigned col);
        int unsigned                     pick;
        logic [sgr_pkg::CFG_INDEX_W-1:0] spare;
        write_reg(sgr_pkg::CFG_CANVAS_WIDTH, cw, sgr_pkg::CANVAS_W);
        write_reg(sgr_pkg::CFG_CANVAS_HEIGHT, ch, sgr_pkg::CANVAS_W);
        write_reg(sgr_pkg::CFG_GLYPH_WIDTH, gw, sgr_pkg::GW_W);
        write_reg(sgr_pkg::CFG_SCALE, sc, sgr_pkg::SCALE_W);
        write_reg(sgr_pkg::CFG_PRIMARY_COLOR, col, sgr_pkg::COLOR_W);
        // Unmapped indexes must leave the registers alone
        pick  = CFG_UNUSED_LO + $urandom_range(0, 2);
        spare = pick[sgr_pkg::CFG_INDEX_W-1:0];
        write_reg(spare, $urandom, 0);
    endtask

    // Offer one row word and hold it until accepted
    task automatic send_row(logic [7:0] bits, logic [2:0] row, logic [9:0] ox, logic [9:0] oy);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        row_bits  <= bits;
        row_index <= row;
        origin_x  <= ox;
        origin_y  <= oy;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note_row(bits, row, ox, oy);
    endtask

    // Random row, mostly placed so that it lands on the canvas
    task automatic send_random_row();
        logic [7:0] bits;
        int unsigned xlim;
        int unsigned ylim;
        logic [9:0] ox;
        logic [9:0] oy;
        case ($urandom_range(0, 9))
            0:       bits = 8'h00;
            1:       bits = 8'hFF;
            default: bits = 8'($urandom);
        endcase
        xlim = (sb.canvas_w + 4 > 1023) ? 1023 : sb.canvas_w + 4;
        ylim = (sb.canvas_h + 4 > 1023) ? 1023 : sb.canvas_h + 4;
        ox = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, xlim));
        oy = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, ylim));
        send_row(bits, 3'($urandom), ox, oy);
    endtask

    // Drop valid and wait for every owed span, then let the block settle
    task automatic drain_spans();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 1023;
            3, 4:    return $urandom_range(1, 1023);
            default: return $urandom_range(8, 200);
        endcase
    endfunction

    function automatic int unsigned pick_gw();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(9, 15);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_scale();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(9, 15);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty row, full row, off canvas, corners
        send_row(8'h00, 3'd0, 10'd10, 10'd10);
        send_row(8'hFF, 3'd0, 10'd0, 10'd0);
        send_row(8'hFF, 3'd7, 10'd1023, 10'd1023);
        send_row(8'h80, 3'd3, 10'd159, 10'd143);
        send_row(8'h01, 3'd7, 10'd152, 10'd136);
        send_row(8'hAA, 3'd5, 10'd155, 10'd20);
        send_row(8'h55, 3'd2, 10'd0, 10'd143);
        drain_spans();

        // Small canvas, scale 3: right edge clip and bottom clip
        set_all(20, 12, 8, 3, 16'h1234);
        send_row(8'hFF, 3'd0, 10'd0, 10'd0);
        send_row(8'hFF, 3'd3, 10'd15, 10'd2);
        send_row(8'h81, 3'd0, 10'd19, 10'd10);
        send_row(8'hC3, 3'd7, 10'd0, 10'd0);
        drain_spans();

        // Scale zero, then glyph width zero: nothing drawn
        set_all(160, 144, 8, 0, 16'hFFFF);
        send_row(8'hFF, 3'd0, 10'd0, 10'd0);
        drain_spans();
        set_all(160, 144, 0, 2, 16'h0F0F);
        send_row(8'hFF, 3'd1, 10'd4, 10'd4);
        drain_spans();

        // Oversized glyph width and scale saturate, largest canvas
        set_all(1023, 1023, 15, 15, 16'h0000);
        send_row(8'hFF, 3'd7, 10'd1023, 10'd1023);
        send_row(8'hFF, 3'd7, 10'd1000, 10'd960);
        send_row(8'hFF, 3'd0, 10'd0, 10'd0);
        drain_spans();

        // Zero width canvas drops all; one pixel canvas keeps one span
        set_all(0, 144, 8, 1, 16'hA5A5);
        send_row(8'hFF, 3'd0, 10'd0, 10'd0);
        drain_spans();
        set_all(1, 1, 1, 1, 16'h5A5A);
        send_row(8'h80, 3'd0, 10'd0, 10'd0);
        send_row(8'h7F, 3'd0, 10'd0, 10'd0);
        drain_spans();

        // Hold the receiver off while full rows keep coming: queue fills up
        set_all(1023, 1023, 8, 8, $urandom_range(0, 65535));
        burst    = 1'b1;
        hold_req = 1'b1;
        repeat (8)
            send_row(8'hFF, 3'($urandom), 10'($urandom_range(0, 500)),
                     10'($urandom_range(0, 500)));
        burst = 1'b0;
        drain_spans();

        // Random phases, each with fresh settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_all(pick_dim(), pick_dim(), pick_gw(), pick_scale(),
                    ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(0, 65535));
            burst = (p % 3 == 1);
            repeat (ROWS_PER_PHASE)
                send_random_row();
            burst = 1'b0;
            drain_spans();
        end

        if (sb.pending() > 0)
            sb.report_mismatch($sformatf("%0d spans never arrived", sb.pending()));
        if (sb.error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_fifo.sv
hw/rtl/sgr_front.sv
hw/rtl/sgr_back.sv
hw/rtl/scaled_glyph_row_rasterizer.sv
bench/scaled_glyph_row_rasterizer_tb.sv
